// File: rtl/doubly_linked_list_engine_defines.svh
// Assertion macros for the doubly linked list engine checker.
// No dependencies; taken in by the checker file.
`ifndef DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH
`define DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define DLLE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dlle check failed");

// next-cycle implication
`define DLLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dlle check failed");

`endif

// File: rtl/dlle_pkg.sv
// Shared types and codes for the doubly linked list engine.
// No dependencies.
package dlle_pkg;

    localparam int ACT_W = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int STS_W = 3;
    localparam int LEN_W = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_DEL_AT    = 3'd5,
        ACT_FIND      = 3'd6,
        ACT_REVERSE   = 3'd7
    } action_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_EMPTY     = 3'd1,
        STS_RANGE     = 3'd2,
        STS_FULL      = 3'd3,
        STS_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_WALK,
        ST_ALLOC,
        ST_LINK1,
        ST_LINK2,
        ST_FIN
    } state_t;

endpackage

// File: rtl/dlle_ram.sv
// Single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dlle_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/dlle_ctrl.sv
// List sequencer: node value/link memories, free stack and the control FSM.
// Depends on dlle_pkg and dlle_ram.
module dlle_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dlle_pkg::ACT_W-1:0]  s_action,
    input  logic signed [dlle_pkg::VAL_W-1:0] s_value,
    input  logic [dlle_pkg::POS_W-1:0]  s_position,
    output logic                        r_valid,
    input  logic                        r_ready,
    output logic [dlle_pkg::STS_W-1:0]  r_status,
    output logic signed [dlle_pkg::VAL_W-1:0] r_found,
    output logic [dlle_pkg::LEN_W-1:0]  r_length
);
    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int XW = ((LW > dlle_pkg::POS_W) ? LW : dlle_pkg::POS_W) + 1;
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);
    localparam logic [LW-1:0] CAP = LW'(CAPACITY);

    dlle_pkg::state_t  state_reg, state_next;
    dlle_pkg::action_t act_reg, act_next;
    logic [dlle_pkg::VAL_W-1:0] val_reg, val_next;
    logic [dlle_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [LW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [LW-1:0] cnt_reg, cnt_next, stk_reg, stk_next, fresh_reg, fresh_next;
    logic [LW-1:0] cur_reg, cur_next, hops_reg, hops_next;
    logic [LW-1:0] pl_reg, pl_next, nx_reg, nx_next, node_reg, node_next;
    dlle_pkg::status_t sts_reg, sts_next;
    logic [dlle_pkg::VAL_W-1:0] found_reg, found_next;

    logic [IW-1:0] node_raddr, fs_raddr;
    logic          val_we, nxt_we, prv_we, fs_we;
    logic [IW-1:0] val_wa, nxt_wa, prv_wa, fs_wa;
    logic [dlle_pkg::VAL_W-1:0] val_wd, val_rd;
    logic [LW-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;
    logic [IW-1:0] fs_wd, fs_rd;

    logic [XW-1:0] posx, cntx;
    logic [LW-1:0] tgt, nsel;

    dlle_ram #(.W(dlle_pkg::VAL_W), .D(CAPACITY)) u_val (
        .aclk(aclk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
        .raddr(node_raddr), .rdata(val_rd));
    dlle_ram #(.W(LW), .D(CAPACITY)) u_nxt (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
        .raddr(node_raddr), .rdata(nxt_rd));
    dlle_ram #(.W(LW), .D(CAPACITY)) u_prv (
        .aclk(aclk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
        .raddr(node_raddr), .rdata(prv_rd));
    dlle_ram #(.W(IW), .D(CAPACITY)) u_fs (
        .aclk(aclk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
        .raddr(fs_raddr), .rdata(fs_rd));

    assign s_ready  = (state_reg == dlle_pkg::ST_IDLE);
    assign r_valid  = (state_reg == dlle_pkg::ST_FIN);
    assign r_status = sts_reg;
    assign r_found  = found_reg;
    assign r_length = dlle_pkg::LEN_W'(cnt_reg);
    assign posx     = XW'(pos_reg);
    assign cntx     = XW'(cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dlle_pkg::ST_IDLE;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            cnt_reg   <= '0;
            stk_reg   <= '0;
            fresh_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            stk_reg   <= stk_next;
            fresh_reg <= fresh_next;
        end
        act_reg   <= act_next;
        val_reg   <= val_next;
        pos_reg   <= pos_next;
        cur_reg   <= cur_next;
        hops_reg  <= hops_next;
        pl_reg    <= pl_next;
        nx_reg    <= nx_next;
        node_reg  <= node_next;
        sts_reg   <= sts_next;
        found_reg <= found_next;
    end

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        stk_next   = stk_reg;
        fresh_next = fresh_reg;
        cur_next   = cur_reg;
        hops_next  = hops_reg;
        pl_next    = pl_reg;
        nx_next    = nx_reg;
        node_next  = node_reg;
        sts_next   = sts_reg;
        found_next = found_reg;
        node_raddr = cur_reg[IW-1:0];
        fs_raddr   = IW'(stk_reg - LW'(1));
        val_we = 1'b0; val_wa = '0; val_wd = val_reg;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = NIL;
        prv_we = 1'b0; prv_wa = '0; prv_wd = NIL;
        fs_we  = 1'b0; fs_wa  = stk_reg[IW-1:0]; fs_wd = cur_reg[IW-1:0];
        tgt    = head_reg;
        nsel   = fresh_reg;

        case (state_reg)
            dlle_pkg::ST_IDLE: begin
                if (s_valid) begin
                    act_next   = dlle_pkg::action_t'(s_action);
                    val_next   = s_value;
                    pos_next   = s_position;
                    state_next = dlle_pkg::ST_DEC;
                end
            end
            dlle_pkg::ST_DEC: begin
                sts_next   = dlle_pkg::STS_OK;
                found_next = '0;
                hops_next  = '0;
                state_next = dlle_pkg::ST_FIN;
                case (act_reg)
                    dlle_pkg::ACT_INS_FRONT, dlle_pkg::ACT_INS_BACK,
                    dlle_pkg::ACT_INS_AT: begin
                        if (cnt_reg == CAP) begin
                            sts_next = dlle_pkg::STS_FULL;
                        end else if (act_reg == dlle_pkg::ACT_INS_AT && cnt_reg != '0
                                     && pos_reg != dlle_pkg::POS_W'(1)) begin
                            if (pos_reg == '0 || posx > cntx + XW'(1)) begin
                                sts_next = dlle_pkg::STS_RANGE;
                            end else begin
                                hops_next  = LW'(posx - XW'(2));
                                state_next = dlle_pkg::ST_WALK;
                            end
                        end else if (act_reg == dlle_pkg::ACT_INS_BACK && cnt_reg != '0) begin
                            pl_next    = tail_reg;
                            nx_next    = NIL;
                            state_next = dlle_pkg::ST_ALLOC;
                        end else begin
                            pl_next    = NIL;
                            nx_next    = head_reg;
                            state_next = dlle_pkg::ST_ALLOC;
                        end
                    end
                    dlle_pkg::ACT_DEL_FRONT, dlle_pkg::ACT_DEL_BACK,
                    dlle_pkg::ACT_DEL_AT: begin
                        if (cnt_reg == '0) begin
                            sts_next = dlle_pkg::STS_EMPTY;
                        end else if (act_reg == dlle_pkg::ACT_DEL_AT) begin
                            if (pos_reg == '0 || posx > cntx) begin
                                sts_next = dlle_pkg::STS_RANGE;
                            end else begin
                                hops_next  = LW'(posx - XW'(1));
                                state_next = dlle_pkg::ST_WALK;
                            end
                        end else begin
                            if (act_reg == dlle_pkg::ACT_DEL_BACK) begin
                                tgt = tail_reg;
                            end
                            state_next = dlle_pkg::ST_WALK;
                        end
                    end
                    dlle_pkg::ACT_FIND: begin
                        if (head_reg == NIL) begin
                            sts_next = dlle_pkg::STS_NOT_FOUND;
                        end else begin
                            state_next = dlle_pkg::ST_WALK;
                        end
                    end
                    default: begin
                        if (head_reg != NIL) begin
                            state_next = dlle_pkg::ST_WALK;
                        end
                    end
                endcase
                cur_next   = tgt;
                node_raddr = tgt[IW-1:0];
            end
            dlle_pkg::ST_WALK: begin
                // read data belongs to cur_reg; advance reads the next link directly
                cur_next   = nxt_rd;
                hops_next  = hops_reg - LW'(1);
                node_raddr = nxt_rd[IW-1:0];
                case (act_reg)
                    dlle_pkg::ACT_INS_FRONT, dlle_pkg::ACT_INS_BACK,
                    dlle_pkg::ACT_INS_AT: begin
                        if (hops_reg == '0) begin
                            pl_next    = cur_reg;
                            nx_next    = nxt_rd;
                            state_next = dlle_pkg::ST_ALLOC;
                        end
                    end
                    dlle_pkg::ACT_DEL_FRONT, dlle_pkg::ACT_DEL_BACK,
                    dlle_pkg::ACT_DEL_AT: begin
                        if (hops_reg == '0) begin
                            if (prv_rd != NIL) begin
                                nxt_we = 1'b1;
                                nxt_wa = prv_rd[IW-1:0];
                                nxt_wd = nxt_rd;
                            end else begin
                                head_next = nxt_rd;
                            end
                            if (nxt_rd != NIL) begin
                                prv_we = 1'b1;
                                prv_wa = nxt_rd[IW-1:0];
                                prv_wd = prv_rd;
                            end else begin
                                tail_next = prv_rd;
                            end
                            fs_we      = 1'b1;
                            stk_next   = stk_reg + LW'(1);
                            cnt_next   = cnt_reg - LW'(1);
                            state_next = dlle_pkg::ST_FIN;
                        end
                    end
                    dlle_pkg::ACT_FIND: begin
                        if (val_rd == val_reg) begin
                            found_next = val_rd;
                            state_next = dlle_pkg::ST_FIN;
                        end else if (nxt_rd == NIL) begin
                            sts_next   = dlle_pkg::STS_NOT_FOUND;
                            state_next = dlle_pkg::ST_FIN;
                        end
                    end
                    default: begin
                        nxt_we = 1'b1;
                        nxt_wa = cur_reg[IW-1:0];
                        nxt_wd = prv_rd;
                        prv_we = 1'b1;
                        prv_wa = cur_reg[IW-1:0];
                        prv_wd = nxt_rd;
                        if (nxt_rd == NIL) begin
                            head_next  = tail_reg;
                            tail_next  = head_reg;
                            state_next = dlle_pkg::ST_FIN;
                        end
                    end
                endcase
            end
            dlle_pkg::ST_ALLOC: begin
                state_next = dlle_pkg::ST_LINK1;
            end
            dlle_pkg::ST_LINK1: begin
                if (stk_reg != '0) begin
                    nsel     = LW'(fs_rd);
                    stk_next = stk_reg - LW'(1);
                end else begin
                    fresh_next = fresh_reg + LW'(1);
                end
                node_next  = nsel;
                val_we = 1'b1; val_wa = nsel[IW-1:0]; val_wd = val_reg;
                nxt_we = 1'b1; nxt_wa = nsel[IW-1:0]; nxt_wd = nx_reg;
                prv_we = 1'b1; prv_wa = nsel[IW-1:0]; prv_wd = pl_reg;
                state_next = dlle_pkg::ST_LINK2;
            end
            dlle_pkg::ST_LINK2: begin
                if (pl_reg != NIL) begin
                    nxt_we = 1'b1;
                    nxt_wa = pl_reg[IW-1:0];
                    nxt_wd = node_reg;
                end else begin
                    head_next = node_reg;
                end
                if (nx_reg != NIL) begin
                    prv_we = 1'b1;
                    prv_wa = nx_reg[IW-1:0];
                    prv_wd = node_reg;
                end else begin
                    tail_next = node_reg;
                end
                cnt_next   = cnt_reg + LW'(1);
                state_next = dlle_pkg::ST_FIN;
            end
            dlle_pkg::ST_FIN: begin
                if (r_ready) begin
                    state_next = dlle_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dlle_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// File: rtl/doubly_linked_list_engine.sv
// Input beat to result beat: refused requests and find/reverse on an empty list go from
// ST_DEC to ST_FIN; front/back delete add ST_WALK, front/back insert ST_ALLOC, ST_LINK1
// and ST_LINK2. Find, reverse and positional ops walk nodes in ST_WALK (up to CAPACITY), one
// link memory read per cycle. Throughput: one request in flight; the next beat is taken
// after the result moves to the output register; a waiting result does not block the input.
// Reset (synchronous, aresetn low): list empty, all nodes free; memories are not cleared.
module doubly_linked_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dlle_pkg::ACT_W-1:0]  s_action,
    input  logic signed [dlle_pkg::VAL_W-1:0] s_value,
    input  logic [dlle_pkg::POS_W-1:0]  s_position,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dlle_pkg::STS_W-1:0]  m_status,
    output logic signed [dlle_pkg::VAL_W-1:0] m_found_value,
    output logic [dlle_pkg::LEN_W-1:0]  m_length
);
    logic                        r_valid, r_ready;
    logic [dlle_pkg::STS_W-1:0]  r_status;
    logic signed [dlle_pkg::VAL_W-1:0] r_found;
    logic [dlle_pkg::LEN_W-1:0]  r_length;
    logic                        m_valid_reg;
    logic [dlle_pkg::STS_W-1:0]  m_status_reg;
    logic signed [dlle_pkg::VAL_W-1:0] m_found_reg;
    logic [dlle_pkg::LEN_W-1:0]  m_length_reg;

    dlle_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_action(s_action), .s_value(s_value), .s_position(s_position),
        .r_valid(r_valid), .r_ready(r_ready),
        .r_status(r_status), .r_found(r_found), .r_length(r_length));

    assign r_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (r_ready) begin
            m_valid_reg <= r_valid;
        end
        if (r_ready && r_valid) begin
            m_status_reg <= r_status;
            m_found_reg  <= r_found;
            m_length_reg <= r_length;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_found_reg;
    assign m_length      = m_length_reg;
endmodule

// File: rtl/dlle_checker.sv
// Port-level checks for the doubly linked list engine, bound to the top level.
// Depends on dlle_pkg and doubly_linked_list_engine_defines.svh.
`include "doubly_linked_list_engine_defines.svh"

module dlle_checker #(
    parameter int CAPACITY = 16
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [dlle_pkg::STS_W-1:0]  m_status,
    input logic [dlle_pkg::VAL_W-1:0]  m_found_value,
    input logic [dlle_pkg::LEN_W-1:0]  m_length
);
    `DLLE_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `DLLE_ASSERT_NOW(a_status_code, aclk, aresetn, m_valid, m_status <= dlle_pkg::STS_NOT_FOUND)
    `DLLE_ASSERT_NOW(a_full_len, aclk, aresetn, m_valid && m_status == dlle_pkg::STS_FULL, m_length == dlle_pkg::LEN_W'(CAPACITY))
    `DLLE_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_found_value) && $stable(m_length))
endmodule

bind doubly_linked_list_engine dlle_checker #(.CAPACITY(CAPACITY)) u_dlle_checker (.*);

// File: sim/tb_top.sv
// Testbench for doubly_linked_list_engine: random and directed list requests,
// each result checked against a behavioral list predictor held in a scoreboard class.
// Depends on dlle_pkg and the doubly_linked_list_engine RTL.
module tb_top;

    localparam int CAP = 16;
    localparam int NIL = CAP;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        dlle_pkg::status_t  status;
        logic signed [31:0] found_value;
        logic [4:0]         length;
    } list_result_t;

    class list_scoreboard;
        logic signed [31:0] entries[$];
        list_result_t pending[$];
        int mismatches;

        function void note_request(dlle_pkg::action_t act, logic signed [31:0] val,
                                   logic [4:0] pos);
            list_result_t r;
            logic signed [31:0] rev[$];
            int idx;
            r.status = dlle_pkg::STS_OK;
            r.found_value = '0;
            case (act)
                dlle_pkg::ACT_INS_FRONT, dlle_pkg::ACT_INS_BACK, dlle_pkg::ACT_INS_AT: begin
                    if (entries.size() == CAP) begin
                        r.status = dlle_pkg::STS_FULL;
                    end else if (act == dlle_pkg::ACT_INS_FRONT) begin
                        entries.push_front(val);
                    end else if (act == dlle_pkg::ACT_INS_BACK) begin
                        entries.push_back(val);
                    end else if (entries.size() == 0 || pos == 1) begin
                        entries.push_front(val);
                    end else if (pos == 0 || pos > entries.size() + 1) begin
                        r.status = dlle_pkg::STS_RANGE;
                    end else begin
                        entries.insert(pos - 1, val);
                    end
                end
                dlle_pkg::ACT_DEL_FRONT, dlle_pkg::ACT_DEL_BACK, dlle_pkg::ACT_DEL_AT: begin
                    if (entries.size() == 0) begin
                        r.status = dlle_pkg::STS_EMPTY;
                    end else if (act == dlle_pkg::ACT_DEL_FRONT) begin
                        void'(entries.pop_front());
                    end else if (act == dlle_pkg::ACT_DEL_BACK) begin
                        void'(entries.pop_back());
                    end else if (pos == 0 || pos > entries.size()) begin
                        r.status = dlle_pkg::STS_RANGE;
                    end else begin
                        entries.delete(pos - 1);
                    end
                end
                dlle_pkg::ACT_FIND: begin
                    r.status = dlle_pkg::STS_NOT_FOUND;
                    idx = 0;
                    while (idx < entries.size() && r.status != dlle_pkg::STS_OK) begin
                        if (entries[idx] == val) begin
                            r.status = dlle_pkg::STS_OK;
                            r.found_value = val;
                        end
                        idx++;
                    end
                end
                default: begin
                    foreach (entries[i]) rev.push_front(entries[i]);
                    entries = rev;
                end
            endcase
            r.length = 5'(entries.size());
            pending.push_back(r);
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.found_value !== want.found_value
                    || got.length !== want.length) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected st=%0d val=%0d len=%0d got st=%0d val=%0d len=%0d",
                             want.status, want.found_value, want.length,
                             got.status, got.found_value, got.length);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [2:0] s_action = '0;
    logic signed [31:0] s_value = '0;
    logic [4:0] s_position = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [2:0] m_status;
    logic signed [31:0] m_found_value;
    logic [4:0] m_length;

    list_scoreboard board = new();
    int idle_cycles;
    int rx_wait;
    int rx_draw;
    bit no_gaps;

    always #5 aclk = ~aclk;

    doubly_linked_list_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_value(s_value), .s_position(s_position),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_found_value(m_found_value), .m_length(m_length)
    );

    // one request beat, with its random lead-in gap
    task automatic send_request(dlle_pkg::action_t act, logic signed [31:0] val,
                                logic [4:0] pos);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_action <= act;
        s_value <= val;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        board.note_request(act, val, pos);
    endtask

    function automatic logic signed [31:0] pick_value();
        int known;
        known = board.entries.size();
        if (known > 0 && $urandom_range(0, 2) == 0)
            return board.entries[$urandom_range(0, known - 1)];
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return 32'sh8000_0000 | $urandom_range(0, 3);
            2: return 32'sh7fff_ffff - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // receiver: after each result beat, hold ready low for a drawn number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            board.check_result('{dlle_pkg::status_t'(m_status), m_found_value, m_length});
            rx_draw = no_gaps ? 0 : $urandom_range(0, 18);
            rx_wait <= rx_draw;
            m_ready <= (rx_draw == 0);
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            rx_wait <= 0;
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int drain;
        dlle_pkg::action_t act;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty-list cases, fill to one below capacity, extremes, reverse, range errors
        send_request(dlle_pkg::ACT_DEL_FRONT, 0, 5'd1);
        send_request(dlle_pkg::ACT_DEL_BACK, 0, 5'd1);
        send_request(dlle_pkg::ACT_DEL_AT, 0, 5'd1);
        send_request(dlle_pkg::ACT_FIND, 0, 5'd1);
        send_request(dlle_pkg::ACT_REVERSE, 0, 5'd1);
        send_request(dlle_pkg::ACT_INS_AT, 32'sh8000_0000, 5'd31);
        send_request(dlle_pkg::ACT_REVERSE, 0, 5'd0);
        send_request(dlle_pkg::ACT_INS_AT, 32'sh7fff_ffff, 5'd0);
        send_request(dlle_pkg::ACT_INS_AT, -1, 5'd4);
        send_request(dlle_pkg::ACT_INS_AT, 5, 5'd3);
        for (int i = 0; i < 13; i++) send_request(dlle_pkg::ACT_INS_BACK, i * 3 - 17, 5'd31);
        send_request(dlle_pkg::ACT_INS_FRONT, 1, 5'd1);
        send_request(dlle_pkg::ACT_FIND, 32'sh7fff_ffff, 5'd0);
        send_request(dlle_pkg::ACT_REVERSE, 0, 5'd0);
        send_request(dlle_pkg::ACT_DEL_AT, 0, 5'd17);
        send_request(dlle_pkg::ACT_DEL_AT, 0, 5'd16);

        // random: bias toward inserts when short and deletes when long
        for (int i = 0; i < 1950; i++) begin
            no_gaps = (i / 200) % 3 == 2;
            case ($urandom_range(0, 9))
                0, 1: act = board.entries.size() > 10 ? dlle_pkg::ACT_DEL_AT
                                                      : dlle_pkg::ACT_INS_AT;
                2: act = dlle_pkg::ACT_INS_FRONT;
                3: act = dlle_pkg::ACT_INS_BACK;
                4: act = dlle_pkg::ACT_DEL_FRONT;
                5: act = dlle_pkg::ACT_DEL_BACK;
                6: act = dlle_pkg::ACT_DEL_AT;
                7, 8: act = dlle_pkg::ACT_FIND;
                default: act = dlle_pkg::ACT_REVERSE;
            endcase
            send_request(act, pick_value(),
                         $urandom_range(0, 7) == 0 ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 17)));
        end
        s_valid <= 0;
        no_gaps = 0;

        drain = 0;
        while (board.pending.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (100) @(posedge aclk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
